FILE: design/wpbe_pkg.sv
// shared types and constants for the ws2812 parallel bit encoder
`timescale 1ns / 1ps

package wpbe_pkg;

  // output lines and default channel count
  localparam int unsigned LINES        = 8;
  localparam int unsigned CHANNELS_DEF = 8;

  // bit slots per led row (grb, 8 bits each)
  localparam int unsigned LED_BITS   = 24;
  localparam int unsigned COLOR_BITS = 8;
  localparam int unsigned SLOT_W     = $clog2(LED_BITS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LED_BITS - 1);

  // active channel register
  localparam int unsigned ACT_W = 4;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(8);

  // fixed pulse words
  localparam logic [LINES-1:0] PULSE_ONES  = '1;
  localparam logic [LINES-1:0] PULSE_ZEROS = '0;

  // input word: one led row
  typedef struct packed {
    logic [63:0] green_plane;
    logic [63:0] red_plane;
    logic [63:0] blue_plane;
    logic        last_row;
  } in_word_t;

  // output word: one three-pulse bit slot
  typedef struct packed {
    logic [LINES-1:0] pulse_high;
    logic [LINES-1:0] pulse_data;
    logic [LINES-1:0] pulse_low;
    logic             slot_last;
    logic             frame_last;
  } out_word_t;

  // slot control from the sequencer to the merge stage
  typedef struct packed {
    logic fire;
    logic slot_last;
    logic frame_last;
  } slot_ctrl_t;

endpackage

FILE: design/wpbe_lane.sv
// one channel lane: holds the grb bits of its channel and shifts them out msb first
`timescale 1ns / 1ps

module wpbe_lane
  import wpbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  load,
  input  logic                  shift,
  input  logic [COLOR_BITS-1:0] green,
  input  logic [COLOR_BITS-1:0] red,
  input  logic [COLOR_BITS-1:0] blue,
  output logic                  bit_out
);

  logic [LED_BITS-1:0] bits;

  // load a new row or step to the next colour bit
  always_ff @(posedge clk) begin
    if (load) begin
      bits <= {green, red, blue};
    end else if (shift) begin
      bits <= {bits[LED_BITS-2:0], 1'b0};
    end
  end

  assign bit_out = bits[LED_BITS-1];

endmodule

FILE: design/wpbe_merge.sv
// merge stage: gathers lane bits, masks inactive channels, holds the output word
`timescale 1ns / 1ps

module wpbe_merge
  import wpbe_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CHANNELS-1:0] lane_bits,
  input  logic [ACT_W-1:0]    active_channels,
  input  slot_ctrl_t          ctrl,
  input  logic                out_ready,
  output logic                out_valid,
  output out_word_t           out_data,
  output logic                can_take
);

  logic [LINES-1:0] data_bits;

  // channel i sends data only when i is below the active count
  always_comb begin
    data_bits = '0;
    for (int unsigned i = 0; i < CHANNELS; i++) begin
      data_bits[i] = lane_bits[i] & (ACT_W'(i) < active_channels);
    end
  end

  assign can_take = !out_valid || out_ready;

  // output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= ctrl.fire;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (ctrl.fire && can_take) begin
      out_data.pulse_high <= PULSE_ONES;
      out_data.pulse_data <= data_bits;
      out_data.pulse_low  <= PULSE_ZEROS;
      out_data.slot_last  <= ctrl.slot_last;
      out_data.frame_last <= ctrl.frame_last;
    end
  end

endmodule

FILE: design/ws2812_parallel_bit_encoder_top.sv
// top level of the ws2812 parallel bit encoder
`timescale 1ns / 1ps

// Each accepted row word expands into 24 slot words (green, red, blue, msb first),
// one per cycle while the output is taken. The rate is set by the slot counter
// stepping the per-channel lane shift registers; the next row loads in the cycle
// its predecessor's last slot leaves, so rows stream with no gap. A registered
// output word decouples the two sides. active_channels (reset 8) picks how many
// lines carry data; it should be written only when idle.
module ws2812_parallel_bit_encoder_top
  import wpbe_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  logic [ACT_W-1:0]    active_channels;
  logic                busy;
  logic [SLOT_W-1:0]   slot;
  logic                last_row;
  logic                can_take;
  logic                fire;
  logic                at_last;
  logic                load;
  logic [CHANNELS-1:0] lane_bits;
  slot_ctrl_t          ctrl;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_channels <= cfg_wdata;
    end
  end

  // slot sequencing
  assign fire     = busy && can_take;
  assign at_last  = (slot == SLOT_LAST);
  assign in_ready = !busy || (fire && at_last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (load) begin
      busy <= 1'b1;
      slot <= '0;
    end else if (fire) begin
      busy <= !at_last;
      slot <= at_last ? '0 : slot + SLOT_W'(1);
    end
  end

  // frame marker of the row in flight
  always_ff @(posedge clk) begin
    if (load) begin
      last_row <= in_data.last_row;
    end
  end

  // one lane per channel
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    wpbe_lane u_lane (
      .clk     (clk),
      .load    (load),
      .shift   (fire),
      .green   (in_data.green_plane[COLOR_BITS*i +: COLOR_BITS]),
      .red     (in_data.red_plane[COLOR_BITS*i +: COLOR_BITS]),
      .blue    (in_data.blue_plane[COLOR_BITS*i +: COLOR_BITS]),
      .bit_out (lane_bits[i])
    );
  end

  // slot flags for the merge stage
  assign ctrl.fire       = fire;
  assign ctrl.slot_last  = at_last;
  assign ctrl.frame_last = at_last && last_row;

  wpbe_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk             (clk),
    .rst             (rst),
    .lane_bits       (lane_bits),
    .active_channels (active_channels),
    .ctrl            (ctrl),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .can_take        (can_take)
  );

endmodule
